// ===== src/scsa_pkg.sv =====
`timescale 1ns / 1ps

package scsa_pkg;

	// Field widths
	localparam int ADDR_W      = 20;
	localparam int SLOTS_W     = 18;
	localparam int SLOT_W      = 17;
	localparam int CLS_W       = 2;
	localparam int MAX_CLASSES = 3;
	localparam int DATA_W      = 32;
	localparam int PADDR_W     = 5;
	localparam int SCALE_W     = SLOTS_W + 3;

	// Reciprocals for exact division of a 20-bit value by 3 and by 5
	localparam int RECIP_W               = 20;
	localparam logic [RECIP_W-1:0] RECIP3 = 20'd699051;
	localparam logic [RECIP_W-1:0] RECIP5 = 20'd838861;
	localparam int RECIP3_SH             = 21;
	localparam int RECIP5_SH             = 22;
	localparam int PROD_W                = ADDR_W + RECIP_W;

	// Register reset values
	localparam logic [ADDR_W-1:0]  RST_BASE_MID    = 20'd155540;
	localparam logic [ADDR_W-1:0]  RST_BASE_LARGE  = 20'd388892;
	localparam logic [SLOTS_W-1:0] RST_SLOTS_SMALL = 18'd77770;
	localparam logic [SLOTS_W-1:0] RST_SLOTS_MID   = 18'd77784;
	localparam logic [SLOTS_W-1:0] RST_SLOTS_LARGE = 18'd77777;

	typedef enum logic [CLS_W-1:0] {
		CLS_SMALL = 2'd0,
		CLS_MID   = 2'd1,
		CLS_LARGE = 2'd2
	} size_class_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		STAT_ALLOCATED    = 2'd0,
		STAT_OUT_OF_SLOTS = 2'd1,
		STAT_FREED        = 2'd2,
		STAT_QUEUE_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_BASE_MID    = 3'd0,
		REG_BASE_LARGE  = 3'd1,
		REG_SLOTS_SMALL = 3'd2,
		REG_SLOTS_MID   = 3'd3,
		REG_SLOTS_LARGE = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_ADDR,
		S_FREE_CLASS,
		S_FREE_MUL,
		S_FREE_PUSH
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]                      base_mid;
		logic [ADDR_W-1:0]                      base_large;
		logic [MAX_CLASSES-1:0][SLOTS_W-1:0]    slots;
	} cfg_t;

	// slot * size of the class, wrapped to the address width
	function automatic logic [ADDR_W-1:0] scale_slot(input logic [SLOTS_W-1:0] slot,
			input logic [CLS_W-1:0] cls);
		logic [SCALE_W-1:0] w;
		logic [SCALE_W-1:0] r;
		w = SCALE_W'(slot);
		case (cls)
			CLS_SMALL: r = w << 1;
			CLS_MID:   r = w + (w << 1);
			CLS_LARGE: r = w + (w << 2);
			default:   r = '0;
		endcase
		return r[ADDR_W-1:0];
	endfunction

endpackage

// ===== src/scsa_cfg_regs.sv =====
`timescale 1ns / 1ps

module scsa_cfg_regs import scsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	cfg_reg_t reg_sel;
	logic     wr_en;

	assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write a register on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_mid             <= RST_BASE_MID;
			cfg_q.base_large           <= RST_BASE_LARGE;
			cfg_q.slots[CLS_SMALL]     <= RST_SLOTS_SMALL;
			cfg_q.slots[CLS_MID]       <= RST_SLOTS_MID;
			cfg_q.slots[CLS_LARGE]     <= RST_SLOTS_LARGE;
		end else if (wr_en) begin
			case (reg_sel)
				REG_BASE_MID:    cfg_q.base_mid         <= pwdata[ADDR_W-1:0];
				REG_BASE_LARGE:  cfg_q.base_large       <= pwdata[ADDR_W-1:0];
				REG_SLOTS_SMALL: cfg_q.slots[CLS_SMALL] <= pwdata[SLOTS_W-1:0];
				REG_SLOTS_MID:   cfg_q.slots[CLS_MID]   <= pwdata[SLOTS_W-1:0];
				REG_SLOTS_LARGE: cfg_q.slots[CLS_LARGE] <= pwdata[SLOTS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		case (reg_sel)
			REG_BASE_MID:    prdata = DATA_W'(cfg_q.base_mid);
			REG_BASE_LARGE:  prdata = DATA_W'(cfg_q.base_large);
			REG_SLOTS_SMALL: prdata = DATA_W'(cfg_q.slots[CLS_SMALL]);
			REG_SLOTS_MID:   prdata = DATA_W'(cfg_q.slots[CLS_MID]);
			REG_SLOTS_LARGE: prdata = DATA_W'(cfg_q.slots[CLS_LARGE]);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== src/scsa_free_ram.sv =====
`timescale 1ns / 1ps

module scsa_free_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/scsa_slot_div.sv =====
`timescale 1ns / 1ps

module scsa_slot_div import scsa_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [CLS_W-1:0]  cls,
	input  logic [ADDR_W-1:0] diff,
	output logic [SLOT_W-1:0] slot
);

	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod_s1;
	logic [ADDR_W-1:0]  diff_s1;
	logic [CLS_W-1:0]   cls_s1;

	// Pick the reciprocal of the slot size; the small class divides by shift
	always_comb begin
		case (cls)
			CLS_MID:   recip = RECIP3;
			CLS_LARGE: recip = RECIP5;
			default:   recip = '0;
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(diff) * PROD_W'(recip);
			diff_s1 <= diff;
			cls_s1  <= cls;
		end
	end

	// Take the quotient, truncated to the slot index width
	always_comb begin
		case (cls_s1)
			CLS_MID:   slot = prod_s1[RECIP3_SH+SLOT_W-1:RECIP3_SH];
			CLS_LARGE: slot = prod_s1[RECIP5_SH+SLOT_W-1:RECIP5_SH];
			default:   slot = diff_s1[SLOT_W:1];
		endcase
	end

endmodule

// ===== src/size_class_slot_allocator.sv =====
`timescale 1ns / 1ps

// Slot allocator for three size classes (2, 3 and 5 bytes). One request is
// handled at a time: an allocation picks its slot and then loads its result
// into the output register; a free runs class decode, reciprocal multiply and
// queue push, loading its result with the push. Both loads wait while an
// earlier result is held by rsp_stall; the next request can be taken in the
// cycle after the load. Allocation waits on the registered free-queue read,
// a free on the registered multiplier dividing the offset by the slot size.
// req_stall stays high until the result is loaded into the output register; a
// new request is taken while an earlier result still waits on rsp_stall.
// The free-queue memory holds NUM_CLASSES * FREE_DEPTH entries and is not
// cleared after reset; only entries pushed before are ever popped, so the
// block is ready right after reset.
module size_class_slot_allocator import scsa_pkg::*; #(
	parameter int PAGE_SLOTS  = 4096,
	parameter int FREE_DEPTH  = 8192,
	parameter int NUM_CLASSES = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               req_type,
	input  logic [CLS_W-1:0]   size_class,
	input  logic [ADDR_W-1:0]  byte_address,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [ADDR_W-1:0]  slot_address,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int PTR_W     = $clog2(2 * FREE_DEPTH);
	localparam int MEM_DEPTH = NUM_CLASSES * FREE_DEPTH;
	localparam int MA_W      = $clog2(MEM_DEPTH);
	localparam int NP_W      = SLOTS_W + 2 - $clog2(PAGE_SLOTS);
	localparam int SUM_W     = SLOTS_W + 3;

	// Ring pointer advance over twice the queue depth
	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		logic [PTR_W:0] n;
		n = {1'b0, p} + 1'b1;
		return (n >= (PTR_W+1)'(2 * FREE_DEPTH)) ? '0 : n[PTR_W-1:0];
	endfunction

	// Pending entries between head and tail
	function automatic logic [PTR_W:0] q_count(input logic [PTR_W-1:0] h,
			input logic [PTR_W-1:0] t);
		logic [PTR_W:0] d;
		d = {1'b0, t} - {1'b0, h};
		if (t < h) begin
			d = d + (PTR_W+1)'(2 * FREE_DEPTH);
		end
		return d;
	endfunction

	// Memory address of a ring position within a class's queue
	function automatic logic [MA_W-1:0] mem_addr(input logic [CLS_W-1:0] c,
			input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] i;
		i = (p >= PTR_W'(FREE_DEPTH)) ? p - PTR_W'(FREE_DEPTH) : p;
		return MA_W'(MA_W'(c) * MA_W'(FREE_DEPTH)) + MA_W'(i);
	endfunction

	cfg_t cfg;

	state_t state_q, state_d;

	// per-class state
	logic [MAX_CLASSES-1:0][SLOTS_W-1:0] cursor_q;
	logic [MAX_CLASSES-1:0][SLOTS_W-1:0] limit_q;
	logic [MAX_CLASSES-1:0][NP_W-1:0]    next_page_q;
	logic [MAX_CLASSES-1:0]              exhausted_q;
	logic [MAX_CLASSES-1:0][PTR_W-1:0]   head_q;
	logic [MAX_CLASSES-1:0][PTR_W-1:0]   tail_q;

	// request and result registers
	logic [CLS_W-1:0]   cls_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  diff_q;
	logic [SLOTS_W-1:0] slot_q;
	logic               fail_q;
	logic               from_mem_q;
	logic               rsp_valid_q;
	status_t            status_q;
	logic [ADDR_W-1:0]  slot_address_q;

	// control
	logic ld_req, do_alloc, ld_cls, div_en, push_fin, addr_fin, ld_rsp;
	logic mem_re, mem_we, rsp_free;

	// allocation datapath
	logic               class_ok;
	logic [PTR_W:0]     cnt;
	logic               q_empty;
	logic               a_open, a_live, a_take, a_pop, a_fail, a_exh;
	logic [SUM_W-1:0]   start_w, end_w, lim_w;
	logic [SLOTS_W-1:0] cur_eff, lim_eff;
	logic               f_ok;

	// free datapath
	logic [CLS_W-1:0]   f_cls;
	logic [ADDR_W-1:0]  f_diff;
	logic [SLOT_W-1:0]  div_slot;

	// response datapath
	logic [SLOT_W-1:0]  mem_rdata;
	logic [SLOTS_W-1:0] slot_sel;
	logic [ADDR_W-1:0]  class_base;
	logic               q_over;

	scsa_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scsa_free_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (SLOT_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr(cls_q, tail_q[cls_q])),
		.wdata (div_slot),
		.re    (mem_re),
		.raddr (mem_addr(cls_q, head_q[cls_q])),
		.rdata (mem_rdata)
	);

	scsa_slot_div u_div (
		.clk  (clk),
		.en   (div_en),
		.cls  (cls_q),
		.diff (diff_q),
		.slot (div_slot)
	);

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req_t'(req_type) == REQ_FREE) ? S_FREE_CLASS : S_ALLOC;
				end
			end
			S_ALLOC:      state_d = S_ADDR;
			S_ADDR:       state_d = rsp_free ? S_IDLE : S_ADDR;
			S_FREE_CLASS: state_d = S_FREE_MUL;
			S_FREE_MUL:   state_d = S_FREE_PUSH;
			S_FREE_PUSH:  state_d = rsp_free ? S_IDLE : S_FREE_PUSH;
			default:      state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		ld_req   = 1'b0;
		do_alloc = 1'b0;
		ld_cls   = 1'b0;
		div_en   = 1'b0;
		push_fin = 1'b0;
		addr_fin = 1'b0;
		case (state_q)
			S_IDLE:       ld_req   = req_valid;
			S_ALLOC:      do_alloc = 1'b1;
			S_ADDR:       addr_fin = rsp_free;
			S_FREE_CLASS: ld_cls   = 1'b1;
			S_FREE_MUL:   div_en   = 1'b1;
			S_FREE_PUSH:  push_fin = rsp_free;
			default: ;
		endcase
	end

	assign mem_re = do_alloc && a_pop;
	assign mem_we = push_fin && f_ok;
	assign ld_rsp = push_fin || addr_fin;

	// Decide the source of an allocation; open a page when cursor and queue are empty and the class is not used up
	always_comb begin
		class_ok = (cls_q < CLS_W'(NUM_CLASSES));
		cnt      = q_count(head_q[cls_q], tail_q[cls_q]);
		q_empty  = (cnt == '0);
		a_open   = (cursor_q[cls_q] >= limit_q[cls_q]) && q_empty;
		start_w  = SUM_W'(next_page_q[cls_q]) * SUM_W'(PAGE_SLOTS);
		end_w    = start_w + SUM_W'(PAGE_SLOTS);
		lim_w    = (end_w < SUM_W'(cfg.slots[cls_q])) ? end_w : SUM_W'(cfg.slots[cls_q]);
		a_exh    = (lim_w == SUM_W'(cfg.slots[cls_q]));
		cur_eff  = a_open ? start_w[SLOTS_W-1:0] : cursor_q[cls_q];
		lim_eff  = a_open ? lim_w[SLOTS_W-1:0] : limit_q[cls_q];
		a_live   = class_ok && !(a_open && exhausted_q[cls_q]);
		a_take   = a_live && (cur_eff < lim_eff);
		a_pop    = a_live && !a_take && !q_empty;
		a_fail   = !a_take && !a_pop;
		f_ok     = class_ok && (cnt < (PTR_W+1)'(FREE_DEPTH));
	end

	// Resolve the class of a freed offset
	always_comb begin
		if (addr_q < cfg.base_mid) begin
			f_cls  = CLS_SMALL;
			f_diff = addr_q;
		end else if (addr_q < cfg.base_large) begin
			f_cls  = CLS_MID;
			f_diff = addr_q - cfg.base_mid;
		end else begin
			f_cls  = CLS_LARGE;
			f_diff = addr_q - cfg.base_large;
		end
	end

	// Form the allocated byte offset
	always_comb begin
		slot_sel = from_mem_q ? SLOTS_W'(mem_rdata) : slot_q;
		case (cls_q)
			CLS_MID:   class_base = cfg.base_mid;
			CLS_LARGE: class_base = cfg.base_large;
			default:   class_base = '0;
		endcase
	end

	// Control and per-class state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cursor_q    <= '0;
			limit_q     <= '0;
			next_page_q <= '0;
			exhausted_q <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_alloc && a_live) begin
				if (a_open) begin
					limit_q[cls_q]     <= lim_eff;
					next_page_q[cls_q] <= next_page_q[cls_q] + 1'b1;
					if (a_exh) begin
						exhausted_q[cls_q] <= 1'b1;
					end
				end
				if (a_take) begin
					cursor_q[cls_q] <= cur_eff + 1'b1;
				end else if (a_open) begin
					cursor_q[cls_q] <= cur_eff;
				end
				if (a_pop) begin
					head_q[cls_q] <= ring_next(head_q[cls_q]);
				end
			end
			if (mem_we) begin
				tail_q[cls_q] <= ring_next(tail_q[cls_q]);
			end
			if (ld_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request, intermediate and result payload
	always_ff @(posedge clk) begin
		if (ld_req) begin
			cls_q  <= size_class;
			addr_q <= byte_address;
		end
		if (ld_cls) begin
			cls_q  <= f_cls;
			diff_q <= f_diff;
		end
		if (do_alloc) begin
			slot_q     <= cur_eff;
			fail_q     <= a_fail;
			from_mem_q <= a_pop;
		end
		if (addr_fin) begin
			status_q       <= fail_q ? STAT_OUT_OF_SLOTS : STAT_ALLOCATED;
			slot_address_q <= fail_q ? '0 : class_base + scale_slot(slot_sel, cls_q);
		end else if (push_fin) begin
			status_q       <= f_ok ? STAT_FREED : STAT_QUEUE_FULL;
			slot_address_q <= '0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign slot_address = slot_address_q;

	// Queue occupancy over all classes
	always_comb begin
		q_over = 1'b0;
		for (int k = 0; k < MAX_CLASSES; k++) begin
			if (q_count(head_q[k], tail_q[k]) > (PTR_W+1)'(FREE_DEPTH)) begin
				q_over = 1'b1;
			end
		end
	end

	a_no_ram_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we))
		else $error("free queue read and written in one cycle");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!q_over)
		else $error("free queue holds more than its depth");

	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR && from_mem_q && $past(state_q) == S_ALLOC) |-> $past(mem_re))
		else $error("queued slot used without a memory read");

	a_free_keeps_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE_PUSH) |=> $stable(head_q))
		else $error("free request moved a queue head");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != STAT_ALLOCATED) |-> (slot_address_q == '0))
		else $error("non-allocation result carries an address");

endmodule

// ===== dv/scsa_checker.sv =====
`timescale 1ns / 1ps

module scsa_checker import scsa_pkg::*; #(
	parameter int PAGE_SLOTS  = 4096,
	parameter int FREE_DEPTH  = 8192,
	parameter int NUM_CLASSES = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic               req_type,
	input  logic [CLS_W-1:0]   size_class,
	input  logic [ADDR_W-1:0]  byte_address,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [1:0]         status,
	input  logic [ADDR_W-1:0]  slot_address,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output int                 errors,
	output int                 pending,
	output int unsigned        n_alloc,
	output int unsigned        n_refused,
	output int unsigned        n_freed,
	output int unsigned        n_dropped
);

	typedef struct packed {
		status_t           st;
		logic [ADDR_W-1:0] where;
	} answer_t;

	// Shadow of the configuration registers
	logic [ADDR_W-1:0]  base_mid;
	logic [ADDR_W-1:0]  base_large;
	logic [SLOTS_W-1:0] slot_count [MAX_CLASSES];

	// Per-class page and free-queue bookkeeping
	int unsigned       cursor       [MAX_CLASSES];
	int unsigned       page_end     [MAX_CLASSES];
	int unsigned       pages_opened [MAX_CLASSES];
	logic              used_up      [MAX_CLASSES];
	int unsigned       head         [MAX_CLASSES];
	int unsigned       tail         [MAX_CLASSES];
	logic [SLOT_W-1:0] freed_ring   [MAX_CLASSES*FREE_DEPTH];

	answer_t           answers_due [$];
	answer_t           due;
	status_t           st_next;
	logic [ADDR_W-1:0] where_next;

	function automatic int unsigned queued(input int unsigned c);
		return (tail[c] >= head[c]) ? tail[c] - head[c] : tail[c] + 2 * FREE_DEPTH - head[c];
	endfunction

	function automatic int unsigned ring_step(input int unsigned p);
		return (p + 1 >= 2 * FREE_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic int unsigned slot_bytes(input int unsigned c);
		case (c)
			CLS_SMALL: return 2;
			CLS_MID:   return 3;
			default:   return 5;
		endcase
	endfunction

	function automatic int unsigned region_base(input int unsigned c);
		case (c)
			CLS_SMALL: return 0;
			CLS_MID:   return 32'(base_mid);
			default:   return 32'(base_large);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 100)
			$display("tb: mismatch at %0t ns: %s", $time, what);
	endtask

	// Work out the answer to one request and update the allocator state
	task automatic serve_request(input logic kind, input logic [CLS_W-1:0] cls,
			input logic [ADDR_W-1:0] addr, output status_t st, output logic [ADDR_W-1:0] where);
		int unsigned c, slot, total, start, lim, a;
		logic got;
		st = STAT_OUT_OF_SLOTS;
		where = '0;
		got = 1'b0;
		slot = 0;
		a = 32'(addr);
		if (kind == REQ_ALLOC) begin
			c = 32'(cls);
			if (c < NUM_CLASSES) begin
				// open the next page once the current page and the queue are both dry and the class is not used up
				if (cursor[c] >= page_end[c] && queued(c) == 0 && !used_up[c]) begin
					total = 32'(slot_count[c]);
					start = pages_opened[c] * PAGE_SLOTS;
					lim = (start + PAGE_SLOTS < total) ? start + PAGE_SLOTS : total;
					cursor[c] = start;
					page_end[c] = lim;
					pages_opened[c]++;
					if (lim == total)
						used_up[c] = 1'b1;
				end
				if (cursor[c] < page_end[c]) begin
					slot = cursor[c];
					cursor[c]++;
					got = 1'b1;
				end else if (queued(c) != 0) begin
					slot = 32'(freed_ring[c * FREE_DEPTH + head[c] % FREE_DEPTH]);
					head[c] = ring_step(head[c]);
					got = 1'b1;
				end
				if (got) begin
					st = STAT_ALLOCATED;
					where = ADDR_W'(region_base(c) + slot * slot_bytes(c));
				end
			end
		end else begin
			// find the class by region, then queue the slot index
			if (a < base_mid) begin
				c = CLS_SMALL;
				slot = a / 2;
			end else if (a < base_large) begin
				c = CLS_MID;
				slot = (a - base_mid) / 3;
			end else begin
				c = CLS_LARGE;
				slot = (a - base_large) / 5;
			end
			if (c < NUM_CLASSES && queued(c) < FREE_DEPTH) begin
				freed_ring[c * FREE_DEPTH + tail[c] % FREE_DEPTH] = SLOT_W'(slot);
				tail[c] = ring_step(tail[c]);
				st = STAT_FREED;
			end else begin
				st = STAT_QUEUE_FULL;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mid = RST_BASE_MID;
			base_large = RST_BASE_LARGE;
			slot_count[CLS_SMALL] = RST_SLOTS_SMALL;
			slot_count[CLS_MID] = RST_SLOTS_MID;
			slot_count[CLS_LARGE] = RST_SLOTS_LARGE;
			for (int i = 0; i < MAX_CLASSES; i++) begin
				cursor[i] = 0;
				page_end[i] = 0;
				pages_opened[i] = 0;
				used_up[i] = 1'b0;
				head[i] = 0;
				tail[i] = 0;
			end
			answers_due.delete();
			errors = 0;
			n_alloc = 0;
			n_refused = 0;
			n_freed = 0;
			n_dropped = 0;
			pending <= 0;
		end else begin
			// follow register writes
			if (psel && penable && pwrite && pready) begin
				case (cfg_reg_t'(paddr[PADDR_W-1:2]))
					REG_BASE_MID:    base_mid = pwdata[ADDR_W-1:0];
					REG_BASE_LARGE:  base_large = pwdata[ADDR_W-1:0];
					REG_SLOTS_SMALL: slot_count[CLS_SMALL] = pwdata[SLOTS_W-1:0];
					REG_SLOTS_MID:   slot_count[CLS_MID] = pwdata[SLOTS_W-1:0];
					REG_SLOTS_LARGE: slot_count[CLS_LARGE] = pwdata[SLOTS_W-1:0];
					default: ;
				endcase
			end
			// compare each response transfer with the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("answer with nothing outstanding: status %0d addr %0d",
						status, slot_address));
				end else begin
					due = answers_due.pop_front();
					if (status !== due.st)
						report_mismatch($sformatf("status %0d, expected %0d", status, due.st));
					if (slot_address !== due.where)
						report_mismatch($sformatf("slot_address %0d, expected %0d (status %0d)",
							slot_address, due.where, due.st));
					case (due.st)
						STAT_ALLOCATED:    n_alloc++;
						STAT_OUT_OF_SLOTS: n_refused++;
						STAT_FREED:        n_freed++;
						default:           n_dropped++;
					endcase
				end
			end
			// predict each request transfer
			if (req_valid && !req_stall) begin
				serve_request(req_type, size_class, byte_address, st_next, where_next);
				due.st = st_next;
				due.where = where_next;
				answers_due.push_back(due);
			end
			pending <= answers_due.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb import scsa_pkg::*;;

	localparam int ADDR_TOP    = 777776;
	localparam int REGION_END  = 777777;
	localparam int SLOTS_TOP   = 131072;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 130;
	localparam int CYCLE_LIMIT = 800000;
	localparam logic [CLS_W-1:0] CLS_NONE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic               req_type;
	logic [CLS_W-1:0]   size_class;
	logic [ADDR_W-1:0]  byte_address;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [1:0]         status;
	logic [ADDR_W-1:0]  slot_address;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int                 errors;
	int                 pending;
	int unsigned        n_alloc, n_refused, n_freed, n_dropped;

	int                 cycles = 0;
	int unsigned        burst_left = 0;
	int unsigned        cur_base_mid, cur_base_large;
	int                 hold_asked = 0;
	int                 hold_served = 0;
	int unsigned        stall_left, stall_odds;

	size_class_slot_allocator dut (.*);

	scsa_checker chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: stopped after %0d cycles with %0d answers outstanding", cycles, pending);
			$display("tb: done, errors");
			$finish;
		end
	end

	// Response side: random stall pattern in modes, plus a long hold-off on request
	initial begin
		rsp_stall <= 1'b0;
		stall_left = 0;
		stall_odds = 0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					rsp_stall <= 1'b1;
					@(posedge clk);
				end
			end
			if (stall_left == 0) begin
				stall_left = $urandom_range(8, 60);
				case ($urandom_range(0, 3))
					0:       stall_odds = 0;
					1:       stall_odds = 20;
					2:       stall_odds = 50;
					default: stall_odds = 80;
				endcase
			end
			stall_left--;
			rsp_stall <= ($urandom_range(0, 99) < stall_odds);
		end
	end

	// Offer one request; the sender works in bursts with gaps between them
	task automatic offer_request(input req_t kind, input logic [CLS_W-1:0] cls,
			input logic [ADDR_W-1:0] addr);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		req_valid <= 1'b1;
		req_type <= kind;
		size_class <= cls;
		byte_address <= addr;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic reg_write(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input int unsigned bm, input int unsigned bl,
			input int unsigned ss, input int unsigned sm, input int unsigned sl);
		reg_write(REG_BASE_MID, bm);
		reg_write(REG_BASE_LARGE, bl);
		reg_write(REG_SLOTS_SMALL, ss);
		reg_write(REG_SLOTS_MID, sm);
		reg_write(REG_SLOTS_LARGE, sl);
		cur_base_mid = bm;
		cur_base_large = bl;
	endtask

	// Drop valid and wait until every answer has come back
	task automatic settle;
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly allocations and frees on a region's slot grid, some raw offsets
	task automatic random_item;
		int unsigned pick, c, lo, hi, step;
		logic [ADDR_W-1:0] a;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			c = ($urandom_range(0, 19) == 0) ? CLS_NONE : $urandom_range(0, 2);
			offer_request(REQ_ALLOC, CLS_W'(c), ADDR_W'($urandom_range(0, ADDR_TOP)));
		end else begin
			a = ADDR_W'($urandom_range(0, ADDR_TOP));
			if (pick < 85) begin
				c = $urandom_range(0, 2);
				case (c)
					CLS_SMALL: begin
						lo = 0;
						hi = cur_base_mid;
					end
					CLS_MID: begin
						lo = cur_base_mid;
						hi = cur_base_large;
					end
					default: begin
						lo = cur_base_large;
						hi = REGION_END;
					end
				endcase
				step = (c == CLS_SMALL) ? 2 : (c == CLS_MID) ? 3 : 5;
				if (hi > lo && hi <= REGION_END)
					a = ADDR_W'(lo + step * $urandom_range(0, (hi - 1 - lo) / step));
			end
			offer_request(REQ_FREE, CLS_W'($urandom_range(0, 3)), a);
		end
	endtask

	task automatic random_phase(input int n, input int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_asked++;
			random_item();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_type <= REQ_ALLOC;
		size_class <= CLS_SMALL;
		byte_address <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small class cut to 24 slots, so its first page ends the class
		load_settings(32'(RST_BASE_MID), 32'(RST_BASE_LARGE), 24, 32'(RST_SLOTS_MID),
			32'(RST_SLOTS_LARGE));

		// directed: each class, an unknown class, frees around every region edge
		offer_request(REQ_ALLOC, CLS_SMALL, ADDR_W'(ADDR_TOP));
		offer_request(REQ_ALLOC, CLS_MID, '0);
		offer_request(REQ_ALLOC, CLS_LARGE, ADDR_W'(ADDR_TOP));
		offer_request(REQ_ALLOC, CLS_NONE, '0);
		offer_request(REQ_FREE, CLS_NONE, '0);
		offer_request(REQ_FREE, CLS_SMALL, ADDR_W'(1));
		offer_request(REQ_FREE, CLS_LARGE, ADDR_W'(RST_BASE_MID - 1));
		offer_request(REQ_FREE, CLS_NONE, RST_BASE_MID);
		offer_request(REQ_FREE, CLS_MID, ADDR_W'(RST_BASE_MID + 2));
		offer_request(REQ_FREE, CLS_SMALL, ADDR_W'(RST_BASE_LARGE - 1));
		offer_request(REQ_FREE, CLS_NONE, RST_BASE_LARGE);
		offer_request(REQ_FREE, CLS_LARGE, ADDR_W'(RST_BASE_LARGE + 4));
		offer_request(REQ_FREE, CLS_NONE, ADDR_W'(ADDR_TOP));
		offer_request(REQ_ALLOC, CLS_SMALL, '0);
		offer_request(REQ_ALLOC, CLS_LARGE, '0);
		settle();

		// lower the large class to one slot; the page already open keeps handing out
		reg_write(REG_SLOTS_LARGE, 1);
		repeat (60) offer_request(REQ_ALLOC, CLS_LARGE, ADDR_W'($urandom_range(0, ADDR_TOP)));
		settle();

		random_phase(PHASE_ITEMS, -1);
		settle();

		// both bases at 0: every free lands in the large class with wide indexes
		load_settings(0, 0, SLOTS_TOP, 1, SLOTS_TOP);
		random_phase(PHASE_ITEMS, -1);
		settle();

		// both bases at the top: every free lands in the small class
		load_settings(REGION_END, REGION_END, 1, SLOTS_TOP, 1);
		random_phase(PHASE_ITEMS, -1);
		settle();

		// reset values, with a long response hold-off that backs up the input
		load_settings(32'(RST_BASE_MID), 32'(RST_BASE_LARGE), 32'(RST_SLOTS_SMALL),
			32'(RST_SLOTS_MID), 32'(RST_SLOTS_LARGE));
		random_phase(PHASE_ITEMS, 40);
		settle();

		load_settings($urandom_range(0, REGION_END), $urandom_range(0, REGION_END),
			$urandom_range(1, SLOTS_TOP), $urandom_range(1, SLOTS_TOP),
			$urandom_range(1, SLOTS_TOP));
		random_phase(PHASE_ITEMS, -1);
		settle();

		// queue a run of small-class frees, then allocate them back from the queue
		load_settings(32'(RST_BASE_MID), 32'(RST_BASE_LARGE), 32'(RST_SLOTS_SMALL),
			32'(RST_SLOTS_MID), 32'(RST_SLOTS_LARGE));
		random_phase(PHASE_ITEMS, -1);
		settle();
		repeat (60)
			offer_request(REQ_FREE, CLS_W'($urandom_range(0, 3)),
				ADDR_W'($urandom_range(0, RST_BASE_MID - 1)));
		repeat (40) offer_request(REQ_ALLOC, CLS_SMALL, ADDR_W'($urandom_range(0, ADDR_TOP)));
		settle();
		repeat (8) @(posedge clk);

		$display("tb: %0d answers checked: %0d allocated, %0d out of slots, %0d freed, %0d refused",
			n_alloc + n_refused + n_freed + n_dropped, n_alloc, n_refused, n_freed, n_dropped);
		$display("tb: swept bases at 0 and top, slot counts 1 to 131072, a lowered count, pops after a used-up class");
		if (errors == 0 && pending == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/scsa_pkg.sv
src/scsa_cfg_regs.sv
src/scsa_free_ram.sv
src/scsa_slot_div.sv
src/size_class_slot_allocator.sv
dv/scsa_checker.sv
dv/tb.sv
